/* sv/rrts_pkg.sv */
// Shared types and constants for the round-robin thread scheduler.
// No dependencies; imported by round_robin_thread_scheduler.
package rrts_pkg;

	localparam int RRTS_MAX_THREADS = 16;
	localparam int TID_W            = 4;

	typedef enum logic [1:0] {
		OP_WAKE = 2'd0,
		OP_TICK = 2'd1,
		OP_SET  = 2'd2
	} rrts_op_t;

	typedef enum logic [1:0] {
		ST_WAITING = 2'd0,
		ST_READY   = 2'd1,
		ST_RUNNING = 2'd2,
		ST_DEAD    = 2'd3
	} thr_state_t;

endpackage

/* sv/round_robin_thread_scheduler.sv */
// Round-robin thread scheduler: per-thread state table, ready queue, current thread.
// Depends on rrts_pkg.
// A command is captured in the input register; its result strobe (done) comes from the result register.
// Throughput: one command per cycle; busy stays low. The state table update and the queue
// push/pop both happen in the compute stage, with the queue head prefetched into a register.
// Reset (arst_n low): all threads waiting, queue empty, no current thread, idle id 0.
// Results cannot be stalled; each is shown for one cycle only.
module round_robin_thread_scheduler
	import rrts_pkg::*;
#(
	parameter int MAX_THREADS = RRTS_MAX_THREADS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       operation,
	input  logic [TID_W-1:0] thread_id,
	input  logic [1:0]       new_state,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TID_W-1:0] cfg_data,
	output logic             done,
	output logic [TID_W-1:0] current_thread,
	output logic             current_valid,
	output logic             switched,
	output logic             accepted,
	output logic             nothing_to_run
);

	localparam int PW       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW       = $clog2(MAX_THREADS + 1);
	localparam int ST_DEPTH = (MAX_THREADS < (1 << TID_W)) ? MAX_THREADS : (1 << TID_W);
	localparam int SIW      = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (32'(p) == MAX_THREADS - 1) ? '0 : p + 1'b1;
	endfunction

	// input register
	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [TID_W-1:0] tid_s1;
	thr_state_t       ns_s1;

	// architectural state
	thr_state_t       st_q [ST_DEPTH];
	logic [TID_W-1:0] fifo_mem [MAX_THREADS];
	logic [TID_W-1:0] head_data_q;
	logic [PW-1:0]    head_q, tail_q;
	logic [CW-1:0]    count_q;
	logic [TID_W-1:0] cur_id_q;
	logic             cur_present_q;
	logic [TID_W-1:0] idle_id_q;

	// result register
	logic             done_q, cur_valid_q, switched_q, accepted_q, none_q;
	logic [TID_W-1:0] cur_thread_q;

	logic             tid_ok, cur_ok, fifo_empty, fifo_full;
	thr_state_t       st_tid, st_cur;
	logic             we_a, we_b;
	logic [SIW-1:0]   addr_a, addr_b;
	thr_state_t       data_a;
	logic             push, pop;
	logic [TID_W-1:0] push_data;
	logic [TID_W-1:0] cur_id_d;
	logic             cur_present_d;
	logic             sw_d, acc_d, none_d;
	logic [PW-1:0]    rd_addr;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign tid_ok     = 32'(tid_s1) < MAX_THREADS;
	assign cur_ok     = 32'(cur_id_q) < MAX_THREADS;
	assign st_tid     = tid_ok ? st_q[tid_s1[SIW-1:0]] : ST_WAITING;
	assign st_cur     = cur_ok ? st_q[cur_id_q[SIW-1:0]] : ST_WAITING;
	assign fifo_empty = count_q == '0;
	assign fifo_full  = count_q == CW'(MAX_THREADS);

	always_comb begin
		we_a          = 1'b0;
		addr_a        = tid_s1[SIW-1:0];
		data_a        = ns_s1;
		we_b          = 1'b0;
		addr_b        = head_data_q[SIW-1:0];
		push          = 1'b0;
		push_data     = tid_s1;
		pop           = 1'b0;
		cur_id_d      = cur_id_q;
		cur_present_d = cur_present_q;
		sw_d          = 1'b0;
		acc_d         = 1'b0;
		none_d        = 1'b0;
		if (valid_s1) begin
			case (op_s1)
				OP_WAKE: begin
					if (tid_ok && st_tid == ST_WAITING && !fifo_full) begin
						we_a   = 1'b1;
						data_a = ST_READY;
						push   = 1'b1;
						acc_d  = 1'b1;
					end
				end
				OP_SET: begin
					we_a = tid_ok;
				end
				OP_TICK: begin
					if (fifo_empty) begin
						if (!cur_present_q) begin
							none_d = 1'b1;
						end else if (st_cur != ST_RUNNING) begin
							sw_d     = cur_id_q != idle_id_q;
							cur_id_d = idle_id_q;
						end
					end else begin
						pop = 1'b1;
						if (cur_present_q && st_cur == ST_RUNNING) begin
							we_a      = 1'b1;
							addr_a    = cur_id_q[SIW-1:0];
							data_a    = ST_READY;
							push      = 1'b1;
							push_data = cur_id_q;
						end
						we_b          = 32'(head_data_q) < MAX_THREADS;
						sw_d          = !cur_present_q || cur_id_q != head_data_q;
						cur_id_d      = head_data_q;
						cur_present_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_addr = pop ? ptr_inc(head_q) : head_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[tail_q] <= push_data;
		end
		head_data_q <= (push && tail_q == rd_addr) ? push_data : fifo_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ST_DEPTH; i++) begin
				st_q[i] <= ST_WAITING;
			end
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			cur_id_q      <= '0;
			cur_present_q <= 1'b0;
			idle_id_q     <= '0;
		end else begin
			if (we_a && !(we_b && addr_a == addr_b)) begin
				st_q[addr_a] <= data_a;
			end
			if (we_b) begin
				st_q[addr_b] <= ST_RUNNING;
			end
			if (pop) begin
				head_q <= ptr_inc(head_q);
			end
			if (push) begin
				tail_q <= ptr_inc(tail_q);
			end
			count_q       <= count_q + CW'(push) - CW'(pop);
			cur_id_q      <= cur_id_d;
			cur_present_q <= cur_present_d;
			if (cfg_valid && cfg_ready) begin
				idle_id_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1  <= operation;
			tid_s1 <= thread_id;
			ns_s1  <= thr_state_t'(new_state);
		end
		cur_thread_q <= cur_present_d ? cur_id_d : '0;
		cur_valid_q  <= cur_present_d;
		switched_q   <= sw_d;
		accepted_q   <= acc_d;
		none_q       <= none_d;
	end

	assign done           = done_q;
	assign current_thread = cur_thread_q;
	assign current_valid  = cur_valid_q;
	assign switched       = switched_q;
	assign accepted       = accepted_q;
	assign nothing_to_run = none_q;

endmodule

/* tb/sv/tb_round_robin_thread_scheduler.sv */
// Self-checking testbench for round_robin_thread_scheduler: directed table, then random phases.
// Checked against typed table rows, else an in-bench model with its own ready ring and state table.
// Depends on rrts_pkg and round_robin_thread_scheduler.
module tb_round_robin_thread_scheduler;
	import rrts_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 325;

	typedef struct packed {
		logic [TID_W-1:0] cur_thread;
		logic             cur_valid;
		logic             switched;
		logic             accepted;
		logic             nothing_to_run;
	} sched_result_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [TID_W-1:0] tid;
		logic [1:0]       ns;
		logic             typed;
		sched_result_t    res;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [26] = '{
		'{OP_TICK,   4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{OP_UNUSED, 4'd5,  2'd3, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_WAKE,   4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{OP_WAKE,   4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_SET,    4'd15, 2'd3, 1'b0, '0},
		'{OP_WAKE,   4'd15, 2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_SET,    4'd15, 2'd0, 1'b0, '0},
		'{OP_WAKE,   4'd15, 2'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{OP_TICK,   4'd0,  2'd0, 1'b1, '{4'd0, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_SET,    4'd0,  2'd3, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_SET,    4'd15, 2'd0, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_SET,    4'd0,  2'd0, 1'b0, '0},
		'{OP_WAKE,   4'd0,  2'd0, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_SET,    4'd0,  2'd0, 1'b0, '0},
		'{OP_WAKE,   4'd0,  2'd0, 1'b0, '0},
		'{OP_SET,    4'd0,  2'd2, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0},
		'{OP_SET,    4'd0,  2'd3, 1'b0, '0},
		'{OP_TICK,   4'd0,  2'd0, 1'b0, '0}
	};

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       operation;
	logic [TID_W-1:0] thread_id;
	logic [1:0]       new_state;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [TID_W-1:0] cfg_data;
	logic             done;
	logic [TID_W-1:0] current_thread;
	logic             current_valid;
	logic             switched;
	logic             accepted;
	logic             nothing_to_run;

	// scheduler model state
	thr_state_t       thr_state [RRTS_MAX_THREADS] = '{default: ST_WAITING};
	logic [TID_W-1:0] ready_ring [RRTS_MAX_THREADS] = '{default: '0};
	logic [TID_W-1:0] ring_head = '0;
	logic [TID_W-1:0] ring_tail = '0;
	int               ring_count = 0;
	logic [TID_W-1:0] cur_id = '0;
	logic             cur_present = 1'b0;
	logic [TID_W-1:0] idle_id = '0;

	sched_result_t expected_results [$];
	int            errors = 0;
	int            burst_left = 0;
	bit            gaps_on = 1'b1;

	round_robin_thread_scheduler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.thread_id      (thread_id),
		.new_state      (new_state),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.current_thread (current_thread),
		.current_valid  (current_valid),
		.switched       (switched),
		.accepted       (accepted),
		.nothing_to_run (nothing_to_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic ring_push(input logic [TID_W-1:0] id);
		if (ring_count < RRTS_MAX_THREADS) begin
			ready_ring[ring_tail] = id;
			ring_tail++;
			ring_count++;
		end
	endtask

	task automatic schedule_step(input logic [1:0] op, input logic [TID_W-1:0] tid,
			input logic [1:0] ns, output sched_result_t res);
		logic [TID_W-1:0] nxt;
		res = '0;
		case (op)
		OP_WAKE: begin
			if (thr_state[tid] == ST_WAITING && ring_count < RRTS_MAX_THREADS) begin
				thr_state[tid] = ST_READY;
				ring_push(tid);
				res.accepted = 1'b1;
			end
		end
		OP_SET: thr_state[tid] = thr_state_t'(ns);
		OP_TICK: begin
			if (ring_count == 0) begin
				if (!cur_present) begin
					res.nothing_to_run = 1'b1;
				end else if (thr_state[cur_id] != ST_RUNNING) begin
					res.switched = (cur_id != idle_id);
					cur_id = idle_id;
				end
			end else begin
				nxt = ready_ring[ring_head];
				ring_head++;
				ring_count--;
				if (cur_present && thr_state[cur_id] == ST_RUNNING) begin
					thr_state[cur_id] = ST_READY;
					ring_push(cur_id);
				end
				thr_state[nxt] = ST_RUNNING;
				res.switched = !cur_present || cur_id != nxt;
				cur_id = nxt;
				cur_present = 1'b1;
			end
		end
		default: ;
		endcase
		res.cur_thread = cur_present ? cur_id : '0;
		res.cur_valid = cur_present;
	endtask

	task automatic send_item(input logic [1:0] op, input logic [TID_W-1:0] tid,
			input logic [1:0] ns, input logic typed, input sched_result_t typed_res);
		sched_result_t res;
		start <= 1'b1;
		operation <= op;
		thread_id <= tid;
		new_state <= ns;
		@(posedge clk);
		while (busy) @(posedge clk);
		schedule_step(op, tid, ns, res);
		expected_results.push_back(typed ? typed_res : res);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if (gaps_on) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(0, 20);
		end
	endtask

	// hold off until every result is back, then let the pipeline settle
	task automatic wait_drained();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_idle(input logic [TID_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		idle_id = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual thread %0d", $time,
					current_thread);
			end else begin
				want = expected_results.pop_front();
				check_field("current_thread", want.cur_thread, current_thread);
				check_field("current_valid", want.cur_valid, current_valid);
				check_field("switched", want.switched, switched);
				check_field("accepted", want.accepted, accepted);
				check_field("nothing_to_run", want.nothing_to_run, nothing_to_run);
			end
		end
	end

	initial begin
		int               tick_pct [N_PHASES];
		int               r;
		logic [1:0]       op;
		logic [TID_W-1:0] tid;
		logic [1:0]       ns;
		tick_pct = '{5, 40, 15, 60, 25, 10};
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_WAKE;
		thread_id = '0;
		new_state = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_idle('0);
		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].tid, DIRECTED_ROWS[i].ns,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			write_idle(ph == 0 ? 4'd15 : ph == 1 ? 4'd0 : 4'($urandom_range(0, 15)));
			gaps_on = (ph != 2);
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				tid = 4'($urandom_range(0, 15));
				ns = 2'($urandom_range(0, 3));
				if (r < tick_pct[ph]) begin
					op = OP_TICK;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 55) begin
						op = OP_WAKE;
					end else if (r < 98) begin
						op = OP_SET;
						if ($urandom_range(0, 3) == 0) tid = cur_id;
						if ($urandom_range(0, 9) < 4) ns = ST_WAITING;
					end else begin
						op = OP_UNUSED;
					end
				end
				send_item(op, tid, ns, 1'b0, '0);
			end
		end

		wait_drained();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
